### hw/rtl/bud_pkg.sv
// Shared types and constants for the Bayer unshuffle / demosaic block.
// Used by bud_front, bud_back, the top level and bud_checker; no dependencies of its own.
package bud_pkg;

   localparam int MAX_WIDTH_DEF = 512;   // pixels a row store holds
   localparam int CMD_DEPTH     = 4;     // front-to-back command queue
   localparam int OUT_DEPTH     = 4;     // result queue
   localparam int CFG_ADDR_W    = 3;     // two 32-bit registers
   localparam int CFG_DATA_W    = 32;
   localparam int FW_W          = 10;    // frame_width register
   localparam int FH_W          = 13;    // frame_height register
   localparam int PIX_W         = 8;
   localparam int NUM_BANKS     = 3;     // ring of row stores

   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 10'd352;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd288;

   // register index = paddr[2]
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic MODE_RAW   = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   // control part of a command handed from front to back
   typedef struct packed {
      logic       wr_en;      // store the raw byte
      logic [1:0] wr_slot;    // bank of the row being loaded
      logic       emit;       // produce one pixel
      logic [1:0] nat_slot;   // bank of the emitted row
      logic [1:0] up_slot;    // bank of the row above
      logic       up_valid;   // emitted row is not row 0
      logic       x_odd;
      logic       y_odd;
      logic       inner;      // pixel gets neighbour fill
      logic       row_end;
      logic       frame_end;
   } bud_cmd_type;

   localparam int CMD_FLAG_W = $bits(bud_cmd_type);

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             row_end;
      logic             frame_end;
   } bud_pix_type;

   localparam int PIX_REC_W = $bits(bud_pix_type);

endpackage

### hw/rtl/bud_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bud_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bud_fifo.sv
// Small register-based FIFO used for the command and result queues.
// No dependencies; DEPTH must be a power of two, at least 2.
module bud_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = data_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/bud_front.sv
// Front end: config registers, input acceptance, row/column bookkeeping and
// classification of each item into a store/emit command. Uses bud_pkg.
module bud_front #(
   parameter int MAX_WIDTH = bud_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bud_pkg::CFG_ADDR_W-1:0]  paddr,
   input  logic [bud_pkg::CFG_DATA_W-1:0]  pwdata,
   output logic [bud_pkg::CFG_DATA_W-1:0]  prdata,
   // input items
   input  logic                            push,
   input  logic                            mode,
   input  logic [bud_pkg::PIX_W-1:0]       raw_byte,
   input  logic                            cmd_full,
   // commands to the back end
   output logic                            cmd_push,
   output bud_pkg::bud_cmd_type            cmd,
   output logic [$clog2(MAX_WIDTH)-1:0]    cmd_wr_addr,
   output logic [$clog2(MAX_WIDTH)-1:0]    cmd_rd_addr,
   output logic [bud_pkg::PIX_W-1:0]       cmd_byte
);
   import bud_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WW    = COL_W + 1;

   logic [FW_W-1:0]  frame_width_ff, frame_width_in;
   logic [FH_W-1:0]  frame_height_ff, frame_height_in;
   logic [COL_W-1:0] load_col_ff, load_col_in;
   logic [COL_W-1:0] drain_col_ff, drain_col_in;
   logic [FH_W-1:0]  load_row_ff, load_row_in;
   logic [1:0]       slot_ff, slot_in;

   logic             cfg_wr;
   logic [WW-1:0]    w_sat, w_eff, half, jw, dw, xw, x_wr;
   logic [FH_W-1:0]  h_eff, y;
   logic [COL_W-1:0] x;
   logic             accept, draining, is_flush;
   logic             load_last, drain_last, do_emit, do_write;

   assign cfg_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? CFG_DATA_W'(frame_height_ff)
                                                  : CFG_DATA_W'(frame_width_ff);

   always_comb begin
      // effective frame size
      w_sat = (32'(frame_width_ff) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
                                                     : WW'(frame_width_ff);
      w_eff = {w_sat[WW-1:1], 1'b0};
      if (w_eff < WW'(2)) begin
         w_eff = WW'(2);
      end
      h_eff = (frame_height_ff == '0) ? FH_W'(1) : frame_height_ff;
      half  = w_eff >> 1;

      draining = (load_row_ff >= h_eff);
      is_flush = (mode == MODE_FLUSH);
      accept   = push && !cmd_full;

      // unshuffle: first half of a row are odd pixels, second half even ones
      jw   = WW'(load_col_ff);
      dw   = WW'(drain_col_ff);
      x_wr = (jw < half) ? ((jw << 1) + WW'(1)) : ((jw - half) << 1);

      load_last  = (jw + WW'(1)) >= w_eff;
      drain_last = (dw + WW'(1)) >= w_eff;

      do_emit  = accept && (draining ? is_flush
                                     : (!is_flush && load_row_ff != '0));
      do_write = accept && !draining && !is_flush;
      cmd_push = do_emit || do_write;

      x  = draining ? drain_col_ff : load_col_ff;
      y  = draining ? (h_eff - FH_W'(1)) : (load_row_ff - FH_W'(1));
      xw = WW'(x);

      cmd.wr_en     = do_write;
      cmd.wr_slot   = slot_ff;
      cmd.emit      = do_emit;
      // emitted row is one behind the load row, its upper row two behind
      cmd.nat_slot  = (slot_ff == 2'd0) ? 2'd2 : (slot_ff - 2'd1);
      cmd.up_slot   = (slot_ff == 2'd0) ? 2'd1 : ((slot_ff == 2'd1) ? 2'd2 : 2'd0);
      cmd.up_valid  = (y != '0);
      cmd.x_odd     = x[0];
      cmd.y_odd     = y[0];
      cmd.inner     = (x != '0) && ((xw + WW'(3)) <= w_eff) && (y != '0) &&
                      (({1'b0, y} + (FH_W+1)'(3)) <= {1'b0, h_eff});
      cmd.row_end   = draining ? drain_last : load_last;
      cmd.frame_end = draining && drain_last;
      cmd_wr_addr   = x_wr[COL_W-1:0];
      cmd_rd_addr   = x;
      cmd_byte      = raw_byte;

      // counters
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      load_col_in     = load_col_ff;
      drain_col_in    = drain_col_ff;
      load_row_in     = load_row_ff;
      slot_in         = slot_ff;
      if (cfg_wr) begin
         if (paddr[2] == REG_FRAME_HEIGHT) begin
            frame_height_in = pwdata[FH_W-1:0];
         end else begin
            frame_width_in = pwdata[FW_W-1:0];
         end
         load_col_in  = '0;
         drain_col_in = '0;
         load_row_in  = '0;
         slot_in      = 2'd0;
      end else if (do_emit && draining) begin
         if (drain_last) begin
            drain_col_in = '0;
            load_col_in  = '0;
            load_row_in  = '0;
            slot_in      = 2'd0;
         end else begin
            drain_col_in = drain_col_ff + COL_W'(1);
         end
      end else if (do_write) begin
         if (load_last) begin
            load_col_in  = '0;
            drain_col_in = '0;
            load_row_in  = load_row_ff + FH_W'(1);
            slot_in      = (slot_ff == 2'd2) ? 2'd0 : (slot_ff + 2'd1);
         end else begin
            load_col_in = load_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         load_col_ff     <= '0;
         drain_col_ff    <= '0;
         load_row_ff     <= '0;
         slot_ff         <= 2'd0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         load_col_ff     <= load_col_in;
         drain_col_ff    <= drain_col_in;
         load_row_ff     <= load_row_in;
         slot_ff         <= slot_in;
      end
   end

endmodule

### hw/rtl/bud_back.sv
// Back end: row store banks, store/read of each command and the
// nearest-neighbour fill. Uses bud_pkg and bud_ram.
module bud_back #(
   parameter int MAX_WIDTH = bud_pkg::MAX_WIDTH_DEF,
   parameter int OUT_DEPTH = bud_pkg::OUT_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_empty,
   output logic                               cmd_pop,
   input  bud_pkg::bud_cmd_type               cmd,
   input  logic [$clog2(MAX_WIDTH)-1:0]       cmd_wr_addr,
   input  logic [$clog2(MAX_WIDTH)-1:0]       cmd_rd_addr,
   input  logic [bud_pkg::PIX_W-1:0]          cmd_byte,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
   output logic                               out_push,
   output bud_pkg::bud_pix_type               out_pix
);
   import bud_pkg::*;

   logic [PIX_W-1:0] rd_data [NUM_BANKS];
   logic             s1_emit_ff, s1_emit_in;
   bud_cmd_type      s1_cmd_ff;
   logic [PIX_W-1:0] left_cur_ff, left_cur_in;
   logic [PIX_W-1:0] left_up_ff, left_up_in;
   logic [PIX_W-1:0] nat, up;

   // a command is taken only when the result queue has a place for it
   assign cmd_pop = !cmd_empty &&
                    ((32'(out_count) + 32'(s1_emit_ff)) < 32'(OUT_DEPTH));

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      bud_ram #(
         .WIDTH (PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (cmd_pop && cmd.wr_en && (cmd.wr_slot == 2'(b))),
         .wr_addr (cmd_wr_addr),
         .wr_data (cmd_byte),
         .rd_addr (cmd_rd_addr),
         .rd_data (rd_data[b])
      );
   end

   assign s1_emit_in = cmd_pop && cmd.emit;

   always_comb begin
      case (s1_cmd_ff.nat_slot)
         2'd0:    nat = rd_data[0];
         2'd1:    nat = rd_data[1];
         2'd2:    nat = rd_data[2];
         default: nat = '0;
      endcase
      up = '0;
      if (s1_cmd_ff.up_valid) begin
         case (s1_cmd_ff.up_slot)
            2'd0:    up = rd_data[0];
            2'd1:    up = rd_data[1];
            2'd2:    up = rd_data[2];
            default: up = '0;
         endcase
      end

      out_pix = '0;
      case ({s1_cmd_ff.y_odd, s1_cmd_ff.x_odd})
         2'b00: begin      // green, even row
            out_pix.green = nat;
            if (s1_cmd_ff.inner) begin
               out_pix.red  = left_cur_ff;
               out_pix.blue = up;
            end
         end
         2'b01: begin      // red
            out_pix.red = nat;
            if (s1_cmd_ff.inner) begin
               out_pix.green = left_cur_ff;
               out_pix.blue  = left_up_ff;
            end
         end
         2'b10: begin      // blue
            out_pix.blue = nat;
            if (s1_cmd_ff.inner) begin
               out_pix.green = left_cur_ff;
               out_pix.red   = left_up_ff;
            end
         end
         default: begin    // green, odd row
            out_pix.green = nat;
            if (s1_cmd_ff.inner) begin
               out_pix.blue = left_cur_ff;
               out_pix.red  = up;
            end
         end
      endcase
      out_pix.row_end   = s1_cmd_ff.row_end;
      out_pix.frame_end = s1_cmd_ff.frame_end;
      out_push          = s1_emit_ff;

      left_cur_in = s1_emit_ff ? nat : left_cur_ff;
      left_up_in  = s1_emit_ff ? up  : left_up_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_emit_ff <= 1'b0;
      end else begin
         s1_emit_ff <= s1_emit_in;
      end
      s1_cmd_ff   <= cmd;
      left_cur_ff <= left_cur_in;
      left_up_ff  <= left_up_in;
   end

endmodule

### hw/rtl/bayer_unshuffle_demosaic.sv
// Accepted items go through the command queue, bank read stage and result queue.
// Throughput: one item per cycle while the command queue is not full; each item is
//   one store and/or one pixel, set by the single pass through the row store banks.
// Reset (synchronous, active high): counters and queues clear, registers go to
//   352 x 288; row stores are not cleared, every row is loaded before read.
// Top level of the Bayer unshuffle / nearest-neighbour demosaic block.
// Depends on bud_pkg, bud_front, bud_fifo, bud_back (and bud_ram inside it).
module bayer_unshuffle_demosaic #(
   parameter int MAX_WIDTH = bud_pkg::MAX_WIDTH_DEF,
   parameter int CMD_DEPTH = bud_pkg::CMD_DEPTH,
   parameter int OUT_DEPTH = bud_pkg::OUT_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bud_pkg::CFG_ADDR_W-1:0]  paddr,
   input  logic [bud_pkg::CFG_DATA_W-1:0]  pwdata,
   output logic [bud_pkg::CFG_DATA_W-1:0]  prdata,
   output logic                            pready,
   // input items
   input  logic                            push,
   output logic                            full,
   input  logic                            req_mode,
   input  logic [bud_pkg::PIX_W-1:0]       req_raw_byte,
   // result items
   output logic                            empty,
   input  logic                            pop,
   output logic [bud_pkg::PIX_W-1:0]       rsp_red,
   output logic [bud_pkg::PIX_W-1:0]       rsp_green,
   output logic [bud_pkg::PIX_W-1:0]       rsp_blue,
   output logic                            rsp_row_end,
   output logic                            rsp_frame_end
);
   import bud_pkg::*;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int CMD_W   = CMD_FLAG_W + 2 * COL_W + PIX_W;

   // front -> queue
   logic             f_push;
   bud_cmd_type      f_cmd;
   logic [COL_W-1:0] f_wr_addr, f_rd_addr;
   logic [PIX_W-1:0] f_byte;
   // queue -> back
   logic [CMD_W-1:0] q_data;
   logic             q_empty, q_pop;
   bud_cmd_type      b_cmd;
   logic [COL_W-1:0] b_wr_addr, b_rd_addr;
   logic [PIX_W-1:0] b_byte;
   // back -> result queue
   logic                         o_push;
   bud_pix_type                  o_pix, o_head;
   logic [PIX_REC_W-1:0]         o_data;
   logic [$clog2(OUT_DEPTH+1)-1:0] o_count;

   // register writes complete in the access cycle, never wait
   assign pready = 1'b1;

   // front end: classifies each item and keeps row/column position
   bud_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .push        (push),
      .mode        (req_mode),
      .raw_byte    (req_raw_byte),
      .cmd_full    (full),
      .cmd_push    (f_push),
      .cmd         (f_cmd),
      .cmd_wr_addr (f_wr_addr),
      .cmd_rd_addr (f_rd_addr),
      .cmd_byte    (f_byte)
   );

   // command queue decouples acceptance from the row store pass; its full
   // flag is the input back-pressure
   bud_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_cmd, f_wr_addr, f_rd_addr, f_byte}),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (full),
      .empty     (q_empty),
      .count     ()
   );

   assign {b_cmd, b_wr_addr, b_rd_addr, b_byte} = q_data;

   // back end: store the byte, read both rows, fill missing channels
   bud_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_empty   (q_empty),
      .cmd_pop     (q_pop),
      .cmd         (b_cmd),
      .cmd_wr_addr (b_wr_addr),
      .cmd_rd_addr (b_rd_addr),
      .cmd_byte    (b_byte),
      .out_count   (o_count),
      .out_push    (o_push),
      .out_pix     (o_pix)
   );

   // result queue; the back end never pushes into it while full because it
   // reserves a place before taking a command
   bud_fifo #(
      .WIDTH (PIX_REC_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (o_push),
      .push_data (o_pix),
      .pop       (pop),
      .pop_data  (o_data),
      .full      (),
      .empty     (empty),
      .count     (o_count)
   );

   assign o_head        = o_data;
   assign rsp_red       = o_head.red;
   assign rsp_green     = o_head.green;
   assign rsp_blue      = o_head.blue;
   assign rsp_row_end   = o_head.row_end;
   assign rsp_frame_end = o_head.frame_end;

endmodule

### hw/rtl/bud_checker.sv
// Port-level checks for bayer_unshuffle_demosaic, bound to the top level.
// Depends on bud_pkg for port widths.
module bud_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      pready,
   input logic                      full,
   input logic                      empty,
   input logic                      pop,
   input logic [bud_pkg::PIX_W-1:0] rsp_red,
   input logic [bud_pkg::PIX_W-1:0] rsp_green,
   input logic [bud_pkg::PIX_W-1:0] rsp_blue,
   input logic                      rsp_row_end,
   input logic                      rsp_frame_end
);

   // result queue comes out of reset empty, command queue not full
   a_reset_empty: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // the last pixel of a frame is also the last of its row
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_frame_end) |-> rsp_row_end)
      else $error("frame_end without row_end");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_red) && $stable(rsp_green) &&
                            $stable(rsp_blue) && $stable(rsp_row_end) &&
                            $stable(rsp_frame_end)))
      else $error("result changed while stalled");

   // register port never inserts wait states
   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind bayer_unshuffle_demosaic bud_checker u_bud_checker (
   .clock         (clock),
   .reset         (reset),
   .pready        (pready),
   .full          (full),
   .empty         (empty),
   .pop           (pop),
   .rsp_red       (rsp_red),
   .rsp_green     (rsp_green),
   .rsp_blue      (rsp_blue),
   .rsp_row_end   (rsp_row_end),
   .rsp_frame_end (rsp_frame_end)
);
